### rtl/clb_pkg.sv
// Package for the constellation boundary lookup block.
// Holds table sizes, command codes and the controller/datapath interface structs.
// Depends on nothing; every other file of the block uses it.
package clb_pkg;

  localparam int unsigned MAX_ROWS = 512;
  localparam int unsigned ADDR_W   = $clog2(MAX_ROWS);
  localparam int unsigned CNT_W    = $clog2(MAX_ROWS + 1);
  localparam int unsigned TOTAL_W  = 10;

  localparam int unsigned RA_W     = 21;
  localparam int unsigned DEC_W    = 20;
  localparam int unsigned CON_W    = 7;
  localparam int unsigned QRA_W    = 23;
  localparam int unsigned WRA_W    = QRA_W + 1;
  localparam int unsigned ROW_W    = 2 * RA_W + DEC_W + CON_W;

  localparam logic signed [WRA_W-1:0] TURN_ARCSEC = WRA_W'(1296000);

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic accept;
    logic scan;
    logic finish;
  } clb_cmd_t;

  typedef struct packed {
    logic empty;
    logic more;
    logic pend;
    logic hit;
  } clb_sts_t;

endpackage

### rtl/clb_ctrl.sv
// Controller state machine of the constellation boundary lookup block.
// Sequences transaction acceptance, the query scan and the result strobe.
// Depends on clb_pkg for command codes and the command and status structs.
module clb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        command_i,
  input  clb_pkg::clb_sts_t sts_i,
  output clb_pkg::clb_cmd_t cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;
  logic accept;
  logic finish;

  assign accept = start_i && (state_q == ST_IDLE);
  assign finish = (state_q == ST_SCAN) &&
                  (sts_i.hit || (!sts_i.pend && !sts_i.more));

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((command_i == clb_pkg::CMD_QUERY) && !sts_i.empty) begin
            state_d = ST_SCAN;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign cmd_o.accept = accept;
  assign cmd_o.scan   = (state_q == ST_SCAN);
  assign cmd_o.finish = finish;
  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;

  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(accept) || $past(state_q == ST_SCAN)))
    else $error("Result strobe without an accepted transaction or a scan.");

  a_finish_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> ((state_q == ST_IDLE) && done_q))
    else $error("Scan finish did not return to idle with a result strobe.");

endmodule

### rtl/clb_datapath.sv
// Datapath of the constellation boundary lookup block.
// Holds the boundary row memory, the row counter, the query registers and the match logic.
// Depends on clb_pkg; driven by clb_ctrl through command and status structs.
module clb_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  clb_pkg::clb_cmd_t                 cmd_i,
  input  logic [1:0]                        command_i,
  input  logic [clb_pkg::RA_W-1:0]          row_ra_low_i,
  input  logic [clb_pkg::RA_W-1:0]          row_ra_high_i,
  input  logic signed [clb_pkg::DEC_W-1:0]  row_dec_low_i,
  input  logic [clb_pkg::CON_W-1:0]         row_constellation_i,
  input  logic signed [clb_pkg::QRA_W-1:0]  query_ra_i,
  input  logic signed [clb_pkg::DEC_W-1:0]  query_dec_i,
  output clb_pkg::clb_sts_t                 sts_o,
  output logic                              found_o,
  output logic [clb_pkg::CON_W-1:0]         constellation_o,
  output logic                              table_full_o,
  output logic [clb_pkg::TOTAL_W-1:0]       row_total_o
);

  logic [clb_pkg::ROW_W-1:0] mem [clb_pkg::MAX_ROWS];

  logic [clb_pkg::CNT_W-1:0] count_q, count_d;
  logic [clb_pkg::CNT_W-1:0] addr_q, addr_d;
  logic                      pend_q, pend_d;
  logic [clb_pkg::ROW_W-1:0] rd_q;

  logic signed [clb_pkg::WRA_W-1:0] qra_q;
  logic signed [clb_pkg::DEC_W-1:0] qdec_q;
  logic signed [clb_pkg::WRA_W-1:0] ra_ext;
  logic signed [clb_pkg::WRA_W-1:0] ra_wrap;

  logic                               found_q, found_d;
  logic [clb_pkg::CON_W-1:0]          con_q, con_d;
  logic                               full_q, full_d;
  logic [clb_pkg::TOTAL_W-1:0]        total_q, total_d;

  logic                               wr_en;
  logic                               rd_en;
  logic                               more;
  logic                               hit;
  logic [clb_pkg::RA_W-1:0]           rd_ra_low;
  logic [clb_pkg::RA_W-1:0]           rd_ra_high;
  logic signed [clb_pkg::DEC_W-1:0]   rd_dec_low;
  logic [clb_pkg::CON_W-1:0]          rd_con;
  logic signed [clb_pkg::WRA_W-1:0]   lo_ext;
  logic signed [clb_pkg::WRA_W-1:0]   hi_ext;

  assign ra_ext = clb_pkg::WRA_W'(query_ra_i);

  always_comb begin
    if (ra_ext < 0) begin
      ra_wrap = ra_ext + clb_pkg::TURN_ARCSEC;
    end else if (ra_ext >= clb_pkg::TURN_ARCSEC) begin
      ra_wrap = ra_ext - clb_pkg::TURN_ARCSEC;
    end else begin
      ra_wrap = ra_ext;
    end
  end

  assign more  = (addr_q != count_q);
  assign rd_en = cmd_i.scan && more;
  assign wr_en = cmd_i.accept && (command_i == clb_pkg::CMD_APPEND) &&
                 (count_q < clb_pkg::CNT_W'(clb_pkg::MAX_ROWS));

  assign {rd_ra_low, rd_ra_high, rd_dec_low, rd_con} = rd_q;
  assign lo_ext = $signed({{(clb_pkg::WRA_W - clb_pkg::RA_W){1'b0}}, rd_ra_low});
  assign hi_ext = $signed({{(clb_pkg::WRA_W - clb_pkg::RA_W){1'b0}}, rd_ra_high});
  assign hit    = pend_q && (qdec_q >= rd_dec_low) && (qra_q >= lo_ext) && (qra_q < hi_ext);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[clb_pkg::ADDR_W-1:0]] <= {row_ra_low_i, row_ra_high_i, row_dec_low_i,
                                             row_constellation_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[addr_q[clb_pkg::ADDR_W-1:0]];
    end
  end

  always_comb begin
    count_d = count_q;
    addr_d  = addr_q;
    pend_d  = 1'b0;
    found_d = found_q;
    con_d   = con_q;
    full_d  = full_q;
    total_d = total_q;
    if (cmd_i.accept) begin
      found_d = 1'b0;
      con_d   = '0;
      full_d  = 1'b0;
      total_d = clb_pkg::TOTAL_W'(count_q);
      addr_d  = '0;
      pend_d  = 1'b0;
      case (command_i)
        clb_pkg::CMD_APPEND: begin
          if (wr_en) begin
            count_d = count_q + 1'b1;
            total_d = clb_pkg::TOTAL_W'(count_q + 1'b1);
          end else begin
            full_d = 1'b1;
          end
        end
        clb_pkg::CMD_CLEAR: begin
          count_d = '0;
          total_d = '0;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.scan) begin
      pend_d = rd_en;
      if (rd_en) begin
        addr_d = addr_q + 1'b1;
      end
      if (cmd_i.finish) begin
        found_d = hit;
        con_d   = hit ? rd_con : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      addr_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      addr_q  <= addr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    con_q   <= con_d;
    full_q  <= full_d;
    total_q <= total_d;
    if (cmd_i.accept) begin
      qra_q  <= ra_wrap;
      qdec_q <= query_dec_i;
    end
  end

  assign sts_o.empty = (count_q == '0);
  assign sts_o.more  = more;
  assign sts_o.pend  = pend_q;
  assign sts_o.hit   = hit;

  assign found_o         = found_q;
  assign constellation_o = con_q;
  assign table_full_o    = full_q;
  assign row_total_o     = total_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= clb_pkg::CNT_W'(clb_pkg::MAX_ROWS))
    else $error("Row count exceeds the table depth.");

  a_pend_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ($past(rd_en) && (addr_q <= count_q)))
    else $error("Read data marked valid without a read in the scan.");

endmodule

### rtl/constellation_boundary_lookup.sv
// Top level of the constellation boundary lookup block.
// Joins the controller (clb_ctrl) and the datapath (clb_datapath); uses clb_pkg.
//
// Usage: a transaction is accepted at a rising edge with start_i high and busy_o
// low. command_i selects append of a boundary row, query of a position, or clear.
// Every transaction yields one result, shown for exactly one cycle with done_o high;
// the receiver cannot stall, so it must take the result in that cycle.
// Append, clear and the unused code answer in the cycle after acceptance,
// and busy_o stays low, so such transactions may follow back to back.
// A query holds busy_o high while it scans the row memory one row per cycle in
// load order through its single read port. A query that hits ends its scan at the
// first matching row; a miss scans every stored row, and a query of an empty table
// does not scan and gives its result as an append does.
// Reset clears the row count and the controller; the row memory is not cleared
// and needs no clearing pass, since only rows below the count are ever read.
module constellation_boundary_lookup (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        command_i,
  input  logic [clb_pkg::RA_W-1:0]          row_ra_low_i,
  input  logic [clb_pkg::RA_W-1:0]          row_ra_high_i,
  input  logic signed [clb_pkg::DEC_W-1:0]  row_dec_low_i,
  input  logic [clb_pkg::CON_W-1:0]         row_constellation_i,
  input  logic signed [clb_pkg::QRA_W-1:0]  query_ra_i,
  input  logic signed [clb_pkg::DEC_W-1:0]  query_dec_i,
  output logic                              done_o,
  output logic                              found_o,
  output logic [clb_pkg::CON_W-1:0]         constellation_o,
  output logic                              table_full_o,
  output logic [clb_pkg::TOTAL_W-1:0]       row_total_o
);

  clb_pkg::clb_cmd_t cmd;
  clb_pkg::clb_sts_t sts;

  clb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .busy_o    (busy_o),
    .done_o    (done_o)
  );

  clb_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .command_i           (command_i),
    .row_ra_low_i        (row_ra_low_i),
    .row_ra_high_i       (row_ra_high_i),
    .row_dec_low_i       (row_dec_low_i),
    .row_constellation_i (row_constellation_i),
    .query_ra_i          (query_ra_i),
    .query_dec_i         (query_dec_i),
    .sts_o               (sts),
    .found_o             (found_o),
    .constellation_o     (constellation_o),
    .table_full_o        (table_full_o),
    .row_total_o         (row_total_o)
  );

endmodule

### verif/clb_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the constellation boundary lookup testbench: keeps its own copy of the
// boundary table, predicts the result of every accepted transaction and checks results in order.
// Depends on clb_pkg for widths, the table size and the command codes.
package clb_scoreboard_pkg;
  import clb_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int TURN = 1296000;

  typedef struct packed {
    logic               found;
    logic [CON_W-1:0]   constellation;
    logic               table_full;
    logic [TOTAL_W-1:0] row_total;
  } lookup_result_t;

  class lookup_scoreboard;
    logic [RA_W-1:0]         ra_low_rows[MAX_ROWS];
    logic [RA_W-1:0]         ra_high_rows[MAX_ROWS];
    logic signed [DEC_W-1:0] dec_low_rows[MAX_ROWS];
    logic [CON_W-1:0]        con_rows[MAX_ROWS];
    int                      rows_held;
    int unsigned             mismatches;
    lookup_result_t          expected_results[$];

    function new();
      rows_held = 0;
      mismatches = 0;
    endfunction

    function void note_command(logic [1:0] cmd, logic [RA_W-1:0] ra_low,
                               logic [RA_W-1:0] ra_high, logic signed [DEC_W-1:0] dec_low,
                               logic [CON_W-1:0] con, logic signed [QRA_W-1:0] query_ra,
                               logic signed [DEC_W-1:0] query_dec);
      lookup_result_t res;
      int ra;
      int dec;
      res = '0;
      case (cmd)
        CMD_APPEND: begin
          if (rows_held < MAX_ROWS) begin
            ra_low_rows[rows_held] = ra_low;
            ra_high_rows[rows_held] = ra_high;
            dec_low_rows[rows_held] = dec_low;
            con_rows[rows_held] = con;
            rows_held++;
          end else begin
            res.table_full = 1'b1;
          end
        end
        CMD_QUERY: begin
          ra = int'(query_ra);
          dec = int'(query_dec);
          if (ra < 0) begin
            ra += TURN;
          end else if (ra >= TURN) begin
            ra -= TURN;
          end
          // Rows are scanned in load order and the first match wins.
          for (int i = 0; i < rows_held && !res.found; i++) begin
            if (dec >= int'(dec_low_rows[i]) && ra >= int'(ra_low_rows[i]) &&
                ra < int'(ra_high_rows[i])) begin
              res.found = 1'b1;
              res.constellation = con_rows[i];
            end
          end
        end
        CMD_CLEAR: begin
          rows_held = 0;
        end
        default: begin
        end
      endcase
      res.row_total = TOTAL_W'(rows_held);
      expected_results = {expected_results, res};
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no transaction pending, expected none, actual %0d/%0d/%0d/%0d",
                 $time, got.found, got.constellation, got.table_full, got.row_total);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("found", want.found, got.found);
      compare_field("constellation", want.constellation, got.constellation);
      compare_field("table_full", want.table_full, got.table_full);
      compare_field("row_total", want.row_total, got.row_total);
    endfunction
  endclass

endpackage

### verif/constellation_boundary_lookup_tb.sv
`timescale 1ns / 1ps
// Testbench top for constellation_boundary_lookup: directed and random appends, clears and
// queries under several sender idling phases, every result checked by the scoreboard.
// Depends on clb_pkg, clb_scoreboard_pkg and the block's RTL.
module constellation_boundary_lookup_tb;
  import clb_pkg::*;
  import clb_scoreboard_pkg::*;

  localparam int ITEM_TARGET = 1170;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic [1:0]              command_i;
  logic [RA_W-1:0]         row_ra_low_i;
  logic [RA_W-1:0]         row_ra_high_i;
  logic signed [DEC_W-1:0] row_dec_low_i;
  logic [CON_W-1:0]        row_constellation_i;
  logic signed [QRA_W-1:0] query_ra_i;
  logic signed [DEC_W-1:0] query_dec_i;
  logic                    done_o;
  logic                    found_o;
  logic [CON_W-1:0]        constellation_o;
  logic                    table_full_o;
  logic [TOTAL_W-1:0]      row_total_o;

  lookup_scoreboard boundary_sb;
  lookup_result_t   seen_result;
  int               idle_pct;
  int               items_sent;

  constellation_boundary_lookup u_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .command_i,
    .row_ra_low_i,
    .row_ra_high_i,
    .row_dec_low_i,
    .row_constellation_i,
    .query_ra_i,
    .query_dec_i,
    .done_o,
    .found_o,
    .constellation_o,
    .table_full_o,
    .row_total_o
  );

  always #6 clk_i = ~clk_i;

  // A result is checked before a transaction accepted at the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        seen_result = {found_o, constellation_o, table_full_o, row_total_o};
        boundary_sb.check_result(seen_result);
      end
      if (start_i && !busy_o) begin
        boundary_sb.note_command(command_i, row_ra_low_i, row_ra_high_i, row_dec_low_i,
                                 row_constellation_i, query_ra_i, query_dec_i);
      end
    end
  end

  task automatic issue(input logic [1:0] cmd, input logic [RA_W-1:0] ra_low,
                       input logic [RA_W-1:0] ra_high, input logic signed [DEC_W-1:0] dec_low,
                       input logic [CON_W-1:0] con, input logic signed [QRA_W-1:0] qra,
                       input logic signed [DEC_W-1:0] qdec);
    command_i <= cmd;
    row_ra_low_i <= ra_low;
    row_ra_high_i <= ra_high;
    row_dec_low_i <= dec_low;
    row_constellation_i <= con;
    query_ra_i <= qra;
    query_dec_i <= qdec;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    if (cmd != CMD_UNUSED) begin
      items_sent++;
    end
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic append_row(input int ra_low, input int ra_high, input int dec_low,
                            input int con);
    issue(CMD_APPEND, RA_W'(ra_low), RA_W'(ra_high), DEC_W'(dec_low), CON_W'(con),
          QRA_W'($urandom), DEC_W'($urandom));
  endtask

  task automatic query_position(input int ra, input int dec);
    issue(CMD_QUERY, RA_W'($urandom), RA_W'($urandom), DEC_W'($urandom), CON_W'($urandom),
          QRA_W'(ra), DEC_W'(dec));
  endtask

  task automatic raw_command(input logic [1:0] cmd);
    issue(cmd, RA_W'($urandom), RA_W'($urandom), DEC_W'($urandom), CON_W'($urandom),
          QRA_W'($urandom), DEC_W'($urandom));
  endtask

  task automatic directed_items();
    query_position(-4194304, -524288);
    raw_command(CMD_UNUSED);
    append_row(0, TURN, -324000, 0);
    append_row(2097151, 2097151, 524287, 127);
    append_row(TURN - 1, 2097151, -524288, 87);
    query_position(0, -324000);
    query_position(-1, 0);
    query_position(TURN, 324000);
    query_position(2 * TURN - 1, 524287);
    query_position(-TURN - 1, 0);
    query_position(4194303, 0);
    query_position(-4194304, 0);
    query_position(100, -324001);
    raw_command(CMD_UNUSED);
    raw_command(CMD_CLEAR);
    query_position(100, 0);
    append_row(500, 900, 10, 42);
    query_position(899, 10);
    query_position(900, 10);
    query_position(500, 9);
  endtask

  task automatic random_row();
    int kind;
    int ra_low;
    int ra_high;
    int dec_low;
    int con;
    kind = $urandom_range(9);
    ra_low = $urandom_range(TURN - 1);
    ra_high = ra_low + $urandom_range(150000, 1);
    dec_low = $urandom_range(648000) - 324000;
    con = $urandom_range(87);
    if (kind == 0) begin
      ra_high = $urandom_range(ra_low);
    end else if (kind == 1) begin
      ra_low = $urandom_range(2097151);
      ra_high = $urandom_range(2097151);
    end else if (kind == 2) begin
      dec_low = $urandom_range(1048575) - 524288;
    end else if (kind == 3) begin
      con = $urandom_range(127);
    end
    append_row(ra_low, ra_high, dec_low, con);
  endtask

  task automatic random_query();
    int kind;
    int k;
    int ra_low;
    int ra_high;
    int dec_low;
    int ra;
    int dec;
    kind = $urandom_range(9);
    ra = $urandom_range(TURN - 1);
    dec = $urandom_range(648000) - 324000;
    if (boundary_sb.rows_held > 0 && kind <= 6) begin
      k = $urandom_range(boundary_sb.rows_held - 1);
      ra_low = int'(boundary_sb.ra_low_rows[k]);
      ra_high = int'(boundary_sb.ra_high_rows[k]);
      dec_low = int'(boundary_sb.dec_low_rows[k]);
      ra = ra_low;
      if (ra_high > ra_low) begin
        case ($urandom_range(3))
          0: ra = ra_low;
          1: ra = ra_high - 1;
          default: ra = ra_low + $urandom_range(ra_high - ra_low - 1);
        endcase
      end
      dec = $urandom_range(1) ? dec_low : dec_low + $urandom_range(524287 - dec_low);
      if (kind == 6) begin
        if ($urandom_range(1) || dec_low == -524288) begin
          ra = ra_high;
        end else begin
          dec = dec_low - 1;
        end
      end
      case ($urandom_range(3))
        0: ra -= TURN;
        1: ra += TURN;
        default: begin
        end
      endcase
    end else if (kind == 9) begin
      ra = int'(QRA_W'($urandom)) - 4194304;
      dec = int'(DEC_W'($urandom)) - 524288;
    end
    query_position(ra, dec);
  endtask

  task automatic random_batch();
    int rows;
    int queries;
    rows = ($urandom_range(9) == 0) ? $urandom_range(64, 24) : $urandom_range(12, 1);
    queries = $urandom_range(10, 2);
    if (boundary_sb.rows_held + rows > 80 || $urandom_range(2) == 0) begin
      raw_command(CMD_CLEAR);
    end
    repeat (rows) random_row();
    repeat (queries) begin
      if ($urandom_range(11) == 0) begin
        raw_command(CMD_UNUSED);
      end
      random_query();
    end
  endtask

  task automatic fill_table();
    raw_command(CMD_CLEAR);
    for (int i = 0; i < MAX_ROWS; i++) begin
      append_row(i * 2000, i * 2000 + 2000, -324000 + $urandom_range(1000), $urandom_range(87));
    end
    query_position((MAX_ROWS - 1) * 2000 + 5, 324000);
    query_position(TURN - 1, 324000);
    query_position((MAX_ROWS - 1) * 2000, -324001);
    repeat (3) random_query();
    repeat (3) random_row();
    raw_command(CMD_CLEAR);
  endtask

  initial begin
    int phase_pct[4];
    int phase_end;
    phase_pct = '{0, 84, 20, 0};
    boundary_sb = new();
    items_sent = 0;
    idle_pct = 0;
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    command_i <= CMD_UNUSED;
    row_ra_low_i <= '0;
    row_ra_high_i <= '0;
    row_dec_low_i <= '0;
    row_constellation_i <= '0;
    query_ra_i <= '0;
    query_dec_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_items();
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      if (p == 2) begin
        fill_table();
      end
      phase_end = items_sent + (ITEM_TARGET - MAX_ROWS - 30) / 4;
      while (items_sent < phase_end) begin
        random_batch();
      end
    end
    start_i <= 1'b0;
    while (boundary_sb.expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (MAX_ROWS + 8) @(posedge clk_i);
    if (boundary_sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### constellation_boundary_lookup.f
rtl/clb_pkg.sv
rtl/clb_ctrl.sv
rtl/clb_datapath.sv
rtl/constellation_boundary_lookup.sv
verif/clb_scoreboard_pkg.sv
verif/constellation_boundary_lookup_tb.sv
